FILE: sv/dual_number_alu_defines.svh
// ----------------------------------------------------------------------------
// dual number alu assertion macros
// concurrent check helpers for the files that assert
// ----------------------------------------------------------------------------
`ifndef DUAL_NUMBER_ALU_DEFINES_SVH
`define DUAL_NUMBER_ALU_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define DNA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define DNA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/dna_pkg.sv
// ----------------------------------------------------------------------------
// dna_pkg
// shared widths, codes and word types of the dual number alu
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dna_pkg;

  // number format: signed fixed point, q16.16
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // internal widths
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int MAG_BITS  = 2 * WORD_BITS + 1;
  localparam int NUM_BITS  = 2 * WORD_BITS + 2 * FRAC_BITS;
  localparam int DEN_BITS  = 2 * WORD_BITS;
  localparam int QUO_BITS  = WORD_BITS + 1;
  localparam int ROOT_BITS = (WORD_BITS + FRAC_BITS + 1) / 2;
  localparam int RAD_BITS  = 2 * ROOT_BITS;

  // register stages in the front end (input, decode, products, combine)
  localparam int FRONT_STAGES = 4;

  typedef enum logic [3:0] {
    ACT_ADD   = 4'd0,
    ACT_SUB   = 4'd1,
    ACT_MUL   = 4'd2,
    ACT_DIV   = 4'd3,
    ACT_INV   = 4'd4,
    ACT_SQR   = 4'd5,
    ACT_SCALE = 4'd6,
    ACT_SHIFT = 4'd7,
    ACT_ABS   = 4'd8,
    ACT_SQRT  = 4'd9,
    ACT_CONST = 4'd10,
    ACT_VAR   = 4'd11
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DOMAIN = 2'd1,
    ST_SAT    = 2'd2
  } status_e;

  // where a result part is finally taken from
  typedef enum logic [1:0] {
    SRC_DIRECT = 2'd0,
    SRC_DIV    = 2'd1,
    SRC_ROOT   = 2'd2
  } src_e;

  typedef struct packed {
    logic [3:0]                  action;
    logic signed [WORD_BITS-1:0] a_val;
    logic signed [WORD_BITS-1:0] a_dot;
    logic signed [WORD_BITS-1:0] b_val;
    logic signed [WORD_BITS-1:0] b_dot;
  } dna_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] res_val;
    logic signed [WORD_BITS-1:0] res_dot;
    logic [1:0]                  status;
  } dna_out_t;

  // wide sign-magnitude value before clamping
  typedef struct packed {
    logic                neg;
    logic [MAG_BITS-1:0] mag;
  } wsm_t;

  // one item in flight behind the front end
  typedef struct packed {
    logic                err;
    src_e                val_src;
    logic                dot_div;
    wsm_t                val;
    wsm_t                dot;
    logic [NUM_BITS-1:0] vn;
    logic [DEN_BITS-1:0] vd;
    logic [NUM_BITS-1:0] dn;
    logic [DEN_BITS-1:0] dd;
    logic [RAD_BITS-1:0] rad;
  } dna_job_t;

endpackage

`default_nettype wire

FILE: sv/dna_front.sv
// ----------------------------------------------------------------------------
// dna_front
// input register, operand decode, product stage and per-operation combine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dna_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  dna_pkg::dna_in_t   item_i,
  output logic               valid_o,
  output dna_pkg::dna_job_t  job_o
);
  import dna_pkg::*;

  typedef struct packed {
    logic                 neg;
    logic [WORD_BITS-1:0] mag;
  } sm_t;

  typedef struct packed {
    logic [3:0] action;
    sm_t        av;
    sm_t        ad;
    sm_t        bv;
    sm_t        bd;
  } dec_t;

  typedef struct packed {
    dec_t                 op;
    logic [PROD_BITS-1:0] p_vv;
    logic [PROD_BITS-1:0] p_dv;
    logic [PROD_BITS-1:0] p_vd;
    logic [PROD_BITS-1:0] p_aa;
    logic [PROD_BITS-1:0] p_ad;
    logic [PROD_BITS-1:0] p_bb;
  } prod_t;

  function automatic sm_t decode(logic [WORD_BITS-1:0] x);
    sm_t r;
    r.neg = x[WORD_BITS-1];
    r.mag = r.neg ? (~x + 1'b1) : x;
    return r;
  endfunction

  function automatic wsm_t widen(sm_t x);
    return {x.neg, MAG_BITS'(x.mag)};
  endfunction

  function automatic wsm_t sadd(wsm_t a, wsm_t b);
    wsm_t r;
    if (a.neg == b.neg) begin
      r.neg = a.neg;
      r.mag = a.mag + b.mag;
    end else if (a.mag >= b.mag) begin
      r.neg = a.neg;
      r.mag = a.mag - b.mag;
    end else begin
      r.neg = b.neg;
      r.mag = b.mag - a.mag;
    end
    return r;
  endfunction

  function automatic wsm_t sneg(wsm_t a);
    return {~a.neg, a.mag};
  endfunction

  function automatic wsm_t fshr(wsm_t a);
    return {a.neg, a.mag >> FRAC_BITS};
  endfunction

  logic     v1_q, v2_q, v3_q, v4_q;
  dna_in_t  in_q;
  dec_t     dec_d, dec_q;
  prod_t    prod_d, prod_q;
  dna_job_t job_d, job_q;

  sm_t  av, ad, bv, bd;
  wsm_t w_vv, w_dv, w_vd, w_aa, w_ad2, mul_dot, div_num;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    in_q   <= item_i;
    dec_q  <= dec_d;
    prod_q <= prod_d;
    job_q  <= job_d;
  end

  // operand decode to sign and magnitude
  always_comb begin
    dec_d.action = in_q.action;
    dec_d.av     = decode(in_q.a_val);
    dec_d.ad     = decode(in_q.a_dot);
    dec_d.bv     = decode(in_q.b_val);
    dec_d.bd     = decode(in_q.b_dot);
  end

  // magnitude products
  always_comb begin
    prod_d.op   = dec_q;
    prod_d.p_vv = PROD_BITS'(dec_q.av.mag) * PROD_BITS'(dec_q.bv.mag);
    prod_d.p_dv = PROD_BITS'(dec_q.ad.mag) * PROD_BITS'(dec_q.bv.mag);
    prod_d.p_vd = PROD_BITS'(dec_q.av.mag) * PROD_BITS'(dec_q.bd.mag);
    prod_d.p_aa = PROD_BITS'(dec_q.av.mag) * PROD_BITS'(dec_q.av.mag);
    prod_d.p_ad = PROD_BITS'(dec_q.av.mag) * PROD_BITS'(dec_q.ad.mag);
    prod_d.p_bb = PROD_BITS'(dec_q.bv.mag) * PROD_BITS'(dec_q.bv.mag);
  end

  // signed products and sums
  assign av      = prod_q.op.av;
  assign ad      = prod_q.op.ad;
  assign bv      = prod_q.op.bv;
  assign bd      = prod_q.op.bd;
  assign w_vv    = {av.neg ^ bv.neg, MAG_BITS'(prod_q.p_vv)};
  assign w_dv    = {ad.neg ^ bv.neg, MAG_BITS'(prod_q.p_dv)};
  assign w_vd    = {av.neg ^ bd.neg, MAG_BITS'(prod_q.p_vd)};
  assign w_aa    = {1'b0, MAG_BITS'(prod_q.p_aa)};
  assign w_ad2   = {av.neg ^ ad.neg, MAG_BITS'(prod_q.p_ad) << 1};
  assign mul_dot = sadd(w_dv, w_vd);
  assign div_num = sadd(w_dv, sneg(w_vd));

  // per-operation rules, divider and root operands
  always_comb begin
    job_d         = '0;
    job_d.val_src = SRC_DIRECT;
    case (action_e'(prod_q.op.action))
      ACT_ADD: begin
        job_d.val = sadd(widen(av), widen(bv));
        job_d.dot = sadd(widen(ad), widen(bd));
      end
      ACT_SUB: begin
        job_d.val = sadd(widen(av), sneg(widen(bv)));
        job_d.dot = sadd(widen(ad), sneg(widen(bd)));
      end
      ACT_MUL: begin
        job_d.val = fshr(w_vv);
        job_d.dot = fshr(mul_dot);
      end
      ACT_DIV: begin
        if (bv.mag == '0) begin
          job_d.err = 1'b1;
        end else begin
          job_d.val_src = SRC_DIV;
          job_d.val.neg = av.neg ^ bv.neg;
          job_d.vn      = NUM_BITS'(av.mag) << FRAC_BITS;
          job_d.vd      = DEN_BITS'(bv.mag);
          job_d.dot_div = 1'b1;
          job_d.dot.neg = div_num.neg;
          job_d.dn      = NUM_BITS'(div_num.mag) << FRAC_BITS;
          job_d.dd      = DEN_BITS'(prod_q.p_bb);
        end
      end
      ACT_INV: begin
        if (bv.mag == '0) begin
          job_d.err = 1'b1;
        end else begin
          job_d.val_src = SRC_DIV;
          job_d.val.neg = bv.neg;
          job_d.vn      = NUM_BITS'(1) << (2 * FRAC_BITS);
          job_d.vd      = DEN_BITS'(bv.mag);
          job_d.dot_div = 1'b1;
          job_d.dot.neg = ~bd.neg;
          job_d.dn      = NUM_BITS'(bd.mag) << (2 * FRAC_BITS);
          job_d.dd      = DEN_BITS'(prod_q.p_bb);
        end
      end
      ACT_SQR: begin
        job_d.val = fshr(w_aa);
        job_d.dot = fshr(w_ad2);
      end
      ACT_SCALE: begin
        job_d.val = fshr(w_vv);
        job_d.dot = fshr(w_dv);
      end
      ACT_SHIFT: begin
        job_d.val = sadd(widen(av), widen(bv));
        job_d.dot = widen(ad);
      end
      ACT_ABS: begin
        if (av.mag == '0) begin
          job_d.err = 1'b1;
        end else begin
          job_d.val = {1'b0, MAG_BITS'(av.mag)};
          job_d.dot = {ad.neg ^ av.neg, MAG_BITS'(ad.mag)};
        end
      end
      ACT_SQRT: begin
        if (av.neg || (av.mag == '0)) begin
          job_d.err = 1'b1;
        end else begin
          job_d.val_src = SRC_ROOT;
          job_d.rad     = RAD_BITS'(av.mag) << FRAC_BITS;
          job_d.dot_div = 1'b1;
          job_d.dot.neg = ad.neg;
          job_d.dn      = NUM_BITS'(ad.mag) << FRAC_BITS;
        end
      end
      ACT_CONST: begin
        job_d.val = widen(av);
      end
      ACT_VAR: begin
        job_d.val = widen(av);
        job_d.dot = {1'b0, MAG_BITS'(1) << FRAC_BITS};
      end
      default: begin
        job_d.err = 1'b1;
      end
    endcase
  end

  assign valid_o = v4_q;
  assign job_o   = job_q;

endmodule

`default_nettype wire

FILE: sv/dna_sqrt.sv
// ----------------------------------------------------------------------------
// dna_sqrt
// pipelined digit-by-digit square root, one root bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dna_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  dna_pkg::dna_job_t  job_i,
  output logic               valid_o,
  output dna_pkg::dna_job_t  job_o
);
  import dna_pkg::*;

  localparam int REM_BITS = ROOT_BITS + 2;

  typedef struct packed {
    dna_job_t             job;
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
  } stage_t;

  logic   vld_q  [ROOT_BITS];
  stage_t pipe_q [ROOT_BITS];
  stage_t last;

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
    stage_t              cur, nxt;
    logic                cur_vld;
    logic [REM_BITS+1:0] rem2, trial;

    if (k == 0) begin : g_head
      assign cur_vld = valid_i;
      assign cur     = {job_i, REM_BITS'(0), ROOT_BITS'(0)};
    end else begin : g_link
      assign cur_vld = vld_q[k-1];
      assign cur     = pipe_q[k-1];
    end

    // bring in two radicand bits, try the next root bit
    always_comb begin
      nxt         = cur;
      rem2        = {cur.rem, cur.job.rad[RAD_BITS-1 -: 2]};
      trial       = {2'b00, cur.root, 2'b01};
      nxt.job.rad = cur.job.rad << 2;
      if (rem2 >= trial) begin
        nxt.rem  = REM_BITS'(rem2 - trial);
        nxt.root = {cur.root[ROOT_BITS-2:0], 1'b1};
      end else begin
        nxt.rem  = REM_BITS'(rem2);
        nxt.root = {cur.root[ROOT_BITS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      pipe_q[k] <= nxt;
    end
  end

  // root becomes the value and twice the root the derivative divisor
  assign last = pipe_q[ROOT_BITS-1];

  always_comb begin
    job_o = last.job;
    if (last.job.val_src == SRC_ROOT) begin
      job_o.val_src = SRC_DIRECT;
      job_o.val     = {1'b0, MAG_BITS'(last.root)};
      job_o.dd      = DEN_BITS'({last.root, 1'b0});
    end
  end

  assign valid_o = vld_q[ROOT_BITS-1];

endmodule

`default_nettype wire

FILE: sv/dna_div.sv
// ----------------------------------------------------------------------------
// dna_div
// two-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dna_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  dna_pkg::dna_job_t  job_i,
  output logic               valid_o,
  output dna_pkg::dna_job_t  job_o
);
  import dna_pkg::*;

  typedef struct packed {
    logic [DEN_BITS-1:0] rem;
    logic [QUO_BITS-1:0] low;
    logic [QUO_BITS-1:0] quo;
    logic                ovf;
  } lane_t;

  typedef struct packed {
    dna_job_t job;
    lane_t    lv;
    lane_t    ld;
  } stage_t;

  // quotient too large when the high dividend part reaches the divisor
  function automatic lane_t lane_init(logic [NUM_BITS-1:0] n, logic [DEN_BITS-1:0] d);
    lane_t               r;
    logic [NUM_BITS-1:0] hi;
    hi    = n >> QUO_BITS;
    r.ovf = hi >= NUM_BITS'(d);
    r.rem = DEN_BITS'(hi);
    r.low = n[QUO_BITS-1:0];
    r.quo = '0;
    return r;
  endfunction

  function automatic lane_t lane_step(lane_t a, logic [DEN_BITS-1:0] d);
    lane_t             r;
    logic [DEN_BITS:0] rem2;
    rem2  = {a.rem, a.low[QUO_BITS-1]};
    r     = a;
    r.low = a.low << 1;
    if (rem2 >= {1'b0, d}) begin
      r.rem = DEN_BITS'(rem2 - {1'b0, d});
      r.quo = {a.quo[QUO_BITS-2:0], 1'b1};
    end else begin
      r.rem = DEN_BITS'(rem2);
      r.quo = {a.quo[QUO_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  logic   prep_vld_q;
  stage_t prep_q;
  logic   vld_q  [QUO_BITS];
  stage_t pipe_q [QUO_BITS];
  stage_t last;

  // setup stage: overflow check and first partial remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vld_q <= 1'b0;
    end else begin
      prep_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prep_q.job <= job_i;
    prep_q.lv  <= lane_init(job_i.vn, job_i.vd);
    prep_q.ld  <= lane_init(job_i.dn, job_i.dd);
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
    stage_t cur, nxt;
    logic   cur_vld;

    if (k == 0) begin : g_head
      assign cur_vld = prep_vld_q;
      assign cur     = prep_q;
    end else begin : g_link
      assign cur_vld = vld_q[k-1];
      assign cur     = pipe_q[k-1];
    end

    // one quotient bit on each lane
    always_comb begin
      nxt    = cur;
      nxt.lv = lane_step(cur.lv, cur.job.vd);
      nxt.ld = lane_step(cur.ld, cur.job.dd);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      pipe_q[k] <= nxt;
    end
  end

  // quotients replace the parts that come from division
  assign last = pipe_q[QUO_BITS-1];

  always_comb begin
    job_o = last.job;
    if (last.job.val_src == SRC_DIV) begin
      job_o.val_src = SRC_DIRECT;
      job_o.val.mag = last.lv.ovf ? {MAG_BITS{1'b1}} : MAG_BITS'(last.lv.quo);
    end
    if (last.job.dot_div) begin
      job_o.dot_div = 1'b0;
      job_o.dot.mag = last.ld.ovf ? {MAG_BITS{1'b1}} : MAG_BITS'(last.ld.quo);
    end
  end

  assign valid_o = vld_q[QUO_BITS-1];

endmodule

`default_nettype wire

FILE: sv/dual_number_alu.sv
// ----------------------------------------------------------------------------
// dual_number_alu
// forward-mode dual number arithmetic in signed q16.16, saturating
// ----------------------------------------------------------------------------
//  channel   handshake          word
//  input     start / busy       item_i   (action, a_val, a_dot, b_val, b_dot)
//  result    done_o (strobe)    result_o (res_val, res_dot, status)
//
//  one word accepted per cycle; each result passes, in order, through the
//  4 front stages, 24 square root stages (one root bit each), 1 divider setup
//  stage, 33 divider stages (one quotient bit each) and the output register.
//  reset clears only the valid bits; no state is kept between words.
//  busy is held low: the pipeline never stalls and results are not held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "dual_number_alu_defines.svh"

module dual_number_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  dna_pkg::dna_in_t  item_i,
  output logic              done_o,
  output dna_pkg::dna_out_t result_o
);
  import dna_pkg::*;

  localparam int LATENCY = FRONT_STAGES + ROOT_BITS + 1 + QUO_BITS + 1;
  localparam logic [WORD_BITS-1:0] POS_LIM = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] NEG_LIM = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic                 sat;
    logic [WORD_BITS-1:0] bits;
  } clamp_t;

  function automatic clamp_t clamp(wsm_t x);
    clamp_t              r;
    logic [MAG_BITS-1:0] lim;
    logic [MAG_BITS-1:0] m;
    lim   = (MAG_BITS'(1) << (WORD_BITS - 1)) - MAG_BITS'(!x.neg);
    r.sat = x.mag > lim;
    m     = r.sat ? lim : x.mag;
    if (x.neg) begin
      m = ~m + 1'b1;
    end
    r.bits = m[WORD_BITS-1:0];
    return r;
  endfunction

  logic     front_vld, root_vld, div_vld;
  dna_job_t front_job, root_job, div_job;
  clamp_t   cv, cd;
  logic     done_q;
  dna_out_t res_d, res_q;

  // never stalls
  assign busy = 1'b0;

  dna_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .item_i  (item_i),
    .valid_o (front_vld),
    .job_o   (front_job)
  );

  dna_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_vld),
    .job_i   (front_job),
    .valid_o (root_vld),
    .job_o   (root_job)
  );

  dna_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (root_vld),
    .job_i   (root_job),
    .valid_o (div_vld),
    .job_o   (div_job)
  );

  // saturate both parts and pick the status
  assign cv = clamp(div_job.val);
  assign cd = clamp(div_job.dot);

  always_comb begin
    if (div_job.err) begin
      res_d.res_val = '0;
      res_d.res_dot = '0;
      res_d.status  = ST_DOMAIN;
    end else begin
      res_d.res_val = cv.bits;
      res_d.res_dot = cd.bits;
      res_d.status  = (cv.sat || cd.sat) ? ST_SAT : ST_OK;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // checks
  `DNA_ASSERT_IMPL(a_fixed_latency, clk_i, rst_ni, done_o, $past(start, LATENCY),
                   "result without a start at the pipeline latency")
  `DNA_ASSERT_IMPL(a_domain_zero, clk_i, rst_ni,
                   done_o && (result_o.status == ST_DOMAIN),
                   (result_o.res_val == '0) && (result_o.res_dot == '0),
                   "domain error result carries nonzero parts")
  `DNA_ASSERT_IMPL(a_sat_bound, clk_i, rst_ni,
                   done_o && (result_o.status == ST_SAT),
                   (result_o.res_val == POS_LIM) || (result_o.res_val == NEG_LIM) ||
                   (result_o.res_dot == POS_LIM) || (result_o.res_dot == NEG_LIM),
                   "saturated result has no part at a bound")

endmodule

`default_nettype wire

FILE: test/dual_number_alu_tb.sv
// ----------------------------------------------------------------------------
// dual_number_alu_tb
// drives words of every action into the dual number alu, predicts each
// result with a wide sign-magnitude model and checks results in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_number_alu_tb;
  import dna_pkg::*;

  localparam int LATENCY = 63;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  dna_in_t  item_i;
  logic     done_o;
  dna_out_t result_o;
  int       err_count;
  int       sender_idle_pct;

  dual_number_alu dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // sign-magnitude working value
  typedef struct {
    bit         neg;
    bit [127:0] m;
  } smag_t;

  task automatic report(string what, logic [31:0] got, logic [31:0] exp_v);
    $display("mismatch %s: got %h expected %h", what, got, exp_v);
    err_count++;
  endtask

  class dual_scoreboard;
    dna_out_t pending[$];

    function smag_t mk(bit neg, bit [127:0] m);
      smag_t r;
      r.neg = neg;
      r.m = m;
      return r;
    endfunction

    function smag_t decode(logic [31:0] x);
      logic [31:0] n;
      n = -x;
      return mk(x[31], x[31] ? {96'd0, n} : {96'd0, x});
    endfunction

    function smag_t sadd(smag_t a, smag_t b);
      if (a.neg == b.neg) return mk(a.neg, a.m + b.m);
      if (a.m >= b.m) return mk(a.neg, a.m - b.m);
      return mk(b.neg, b.m - a.m);
    endfunction

    function smag_t neg_of(smag_t a);
      a.neg = !a.neg;
      return a;
    endfunction

    function smag_t smul(smag_t a, smag_t b);
      return mk(a.neg != b.neg, a.m * b.m);
    endfunction

    function smag_t drop_frac(smag_t a);
      a.m = a.m >> FRAC_BITS;
      return a;
    endfunction

    function logic [31:0] clamp(smag_t x, inout bit sat);
      bit [127:0]  lim;
      logic [31:0] bits;
      lim = 128'd1 << (WORD_BITS - 1);
      if (!x.neg) lim = lim - 1;
      if (x.m > lim) begin
        x.m = lim;
        sat = 1'b1;
      end
      bits = x.m[31:0];
      if (x.neg) bits = -bits;
      return bits;
    endfunction

    function bit [127:0] root_of(bit [127:0] x);
      bit [127:0] s;
      bit [127:0] c;
      s = 0;
      for (int i = 31; i >= 0; i--) begin
        c = s | (128'd1 << i);
        if (c * c <= x) s = c;
      end
      return s;
    endfunction

    // expected result of one accepted word
    function void note(dna_in_t it);
      smag_t    av, ad, bv, bd, rv, rd, num;
      bit       err, sat;
      bit [127:0] r;
      dna_out_t o;
      av = decode(it.a_val);
      ad = decode(it.a_dot);
      bv = decode(it.b_val);
      bd = decode(it.b_dot);
      rv = mk(0, 0);
      rd = mk(0, 0);
      err = 0;
      sat = 0;
      case (it.action)
        ACT_ADD: begin
          rv = sadd(av, bv);
          rd = sadd(ad, bd);
        end
        ACT_SUB: begin
          rv = sadd(av, neg_of(bv));
          rd = sadd(ad, neg_of(bd));
        end
        ACT_MUL: begin
          rv = drop_frac(smul(av, bv));
          rd = drop_frac(sadd(smul(ad, bv), smul(av, bd)));
        end
        ACT_DIV: begin
          if (bv.m == 0) err = 1;
          else begin
            num = sadd(smul(ad, bv), neg_of(smul(av, bd)));
            rv = mk(av.neg != bv.neg, (av.m << FRAC_BITS) / bv.m);
            rd = mk(num.neg, (num.m << FRAC_BITS) / (bv.m * bv.m));
          end
        end
        ACT_INV: begin
          if (bv.m == 0) err = 1;
          else begin
            rv = mk(bv.neg, (128'd1 << (2 * FRAC_BITS)) / bv.m);
            rd = mk(!bd.neg, (bd.m << (2 * FRAC_BITS)) / (bv.m * bv.m));
          end
        end
        ACT_SQR: begin
          rv = drop_frac(smul(av, av));
          rd = smul(av, ad);
          rd.m = rd.m << 1;
          rd = drop_frac(rd);
        end
        ACT_SCALE: begin
          rv = drop_frac(smul(av, bv));
          rd = drop_frac(smul(ad, bv));
        end
        ACT_SHIFT: begin
          rv = sadd(av, bv);
          rd = ad;
        end
        ACT_ABS: begin
          if (av.m == 0) err = 1;
          else begin
            rv = av;
            rd = ad;
            if (av.neg) begin
              rv = neg_of(av);
              rd = neg_of(ad);
            end
          end
        end
        ACT_SQRT: begin
          if (av.neg || av.m == 0) err = 1;
          else begin
            r = root_of(av.m << FRAC_BITS);
            rv = mk(0, r);
            rd = mk(ad.neg, (ad.m << FRAC_BITS) / (r << 1));
          end
        end
        ACT_CONST: rv = av;
        ACT_VAR: begin
          rv = av;
          rd = mk(0, 128'd1 << FRAC_BITS);
        end
        default: err = 1;
      endcase
      if (err) begin
        o.res_val = '0;
        o.res_dot = '0;
        o.status = ST_DOMAIN;
      end else begin
        o.res_val = clamp(rv, sat);
        o.res_dot = clamp(rd, sat);
        o.status = sat ? ST_SAT : ST_OK;
      end
      pending.push_back(o);
    endfunction

    // compare one result word with the oldest expectation
    task check(dna_out_t got);
      dna_out_t e;
      if (pending.size() == 0) begin
        report("unexpected result", got.res_val, 32'd0);
        return;
      end
      e = pending.pop_front();
      if (got.res_val !== e.res_val) report("res_val", got.res_val, e.res_val);
      if (got.res_dot !== e.res_dot) report("res_dot", got.res_dot, e.res_dot);
      if (got.status !== e.status) report("status", 32'(got.status), 32'(e.status));
    endtask
  endclass

  dual_scoreboard sb = new();

  // clock, 12 ns period
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // accepted words and result strobes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note(item_i);
      if (done_o) sb.check(result_o);
    end
  end

  // present one word and hold it until accepted
  task automatic send(dna_in_t it);
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    // idle cycles between words
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_op(action_e act, logic [31:0] av, logic [31:0] ad,
                         logic [31:0] bv, logic [31:0] bd);
    dna_in_t it;
    it.action = act;
    it.a_val = av;
    it.a_dot = ad;
    it.b_val = bv;
    it.b_dot = bd;
    send(it);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'(int'($urandom_range(0, 262144)) - 131072);
      2: return 32'(int'($urandom_range(0, 32767)) - 16384) << 8;
      3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      4: return 32'(int'($urandom_range(0, 8)) - 4);
      default: return 32'(int'($urandom_range(0, 16)) - 8) << 16;
    endcase
  endfunction

  task automatic send_random();
    dna_in_t it;
    it.action = ($urandom_range(19) == 0) ? 4'($urandom_range(12, 15))
                                          : 4'($urandom_range(0, 11));
    it.a_val = rand_operand();
    it.a_dot = rand_operand();
    it.b_val = rand_operand();
    it.b_dot = rand_operand();
    send(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    dna_in_t bad;
    err_count = 0;
    sender_idle_pct = 0;
    start = 1'b0;
    item_i = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words: extremes, every action, domain errors, overflow
    send_op(ACT_ADD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_op(ACT_SUB, 32'h80000000, 32'h00010000, 32'h7fffffff, 32'hffff0000);
    send_op(ACT_MUL, 32'h00020000, 32'h00010000, 32'h00030000, 32'h00008000);
    send_op(ACT_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_op(ACT_DIV, 32'h00060000, 32'h00010000, 32'h00020000, 32'h00010000);
    send_op(ACT_DIV, 32'h00010000, 32'h00010000, 32'h00000000, 32'h00010000);
    send_op(ACT_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h7fffffff);
    send_op(ACT_INV, 32'h0, 32'h0, 32'h00020000, 32'h00010000);
    send_op(ACT_INV, 32'h0, 32'h0, 32'h00000000, 32'h00010000);
    send_op(ACT_INV, 32'h0, 32'h0, 32'h80000000, 32'h80000000);
    send_op(ACT_SQR, 32'hfffd0000, 32'h00010000, 32'h0, 32'h0);
    send_op(ACT_SQR, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0);
    send_op(ACT_SCALE, 32'h00030000, 32'hffff0000, 32'hfffe0000, 32'h0);
    send_op(ACT_SHIFT, 32'h7fffffff, 32'h12345678, 32'h00000001, 32'h0);
    send_op(ACT_ABS, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
    send_op(ACT_ABS, 32'h00000000, 32'h00010000, 32'h0, 32'h0);
    send_op(ACT_SQRT, 32'h00040000, 32'h00010000, 32'h0, 32'h0);
    send_op(ACT_SQRT, 32'h00000000, 32'h00010000, 32'h0, 32'h0);
    send_op(ACT_SQRT, 32'hffff0000, 32'h00010000, 32'h0, 32'h0);
    send_op(ACT_SQRT, 32'h00000001, 32'h7fffffff, 32'h0, 32'h0);
    send_op(ACT_CONST, 32'h80000000, 32'h7fffffff, 32'h1, 32'h1);
    send_op(ACT_VAR, 32'h7fffffff, 32'h80000000, 32'h1, 32'h1);
    bad = '0;
    for (int i = 12; i < 16; i++) begin
      bad.action = 4'(i);
      bad.a_val = 32'h00010000;
      send(bad);
    end

    // sender idles now and then
    sender_idle_pct = 19;
    repeat (350) send_random();
    // hold off until everything in flight has come back
    drain();
    // sender idles often
    sender_idle_pct = 63;
    repeat (350) send_random();
    sender_idle_pct = 0;
    repeat (350) send_random();

    drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
